@@ hdl/rrdq_pkg.sv @@
// rrdq_pkg: request codes, status codes, controller states and command bundle
package rrdq_pkg;

  localparam logic [3:0] REQ_PUSH_LEFT  = 4'd0;
  localparam logic [3:0] REQ_PUSH_RIGHT = 4'd1;
  localparam logic [3:0] REQ_POP_LEFT   = 4'd2;
  localparam logic [3:0] REQ_POP_RIGHT  = 4'd3;
  localparam logic [3:0] REQ_PEEK_LEFT  = 4'd4;
  localparam logic [3:0] REQ_PEEK_RIGHT = 4'd5;
  localparam logic [3:0] REQ_GET        = 4'd6;
  localparam logic [3:0] REQ_SET        = 4'd7;
  localparam logic [3:0] REQ_REVERSE    = 4'd8;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_RESP   = 4'b1000
  } rrdq_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic access;
    logic load_out;
  } rrdq_cmd_t;

endpackage

@@ hdl/rrdq_ctrl.sv @@
// rrdq_ctrl: sequencing state machine and handshake control
module rrdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output rrdq_pkg::rrdq_cmd_t cmd
);

  rrdq_pkg::rrdq_state_t state, state_next;
  logic out_free;

  // output register can take a new word when empty or being emptied this cycle
  assign out_free = !out_valid || !out_stall;
  // nothing is taken while reset is held
  assign in_stall = rst || (state != rrdq_pkg::ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      rrdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = rrdq_pkg::ST_DECODE;
        end
      end
      rrdq_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = rrdq_pkg::ST_ACCESS;
      end
      rrdq_pkg::ST_ACCESS: begin
        cmd.access = 1'b1;
        state_next = rrdq_pkg::ST_RESP;
      end
      rrdq_pkg::ST_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = rrdq_pkg::ST_IDLE;
        end
      end
      default: state_next = rrdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrdq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/rrdq_dpath.sv @@
// rrdq_dpath: pointers, element store and result register of the deque
module rrdq_dpath #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rrdq_pkg::rrdq_cmd_t cmd,
  input  logic [3:0]          req_type,
  input  logic [9:0]          index,
  input  logic [31:0]         value,
  output logic [31:0]         read_data,
  output logic [1:0]          status,
  output logic [10:0]         count,
  output logic                is_reversed
);

  localparam int PW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 10) ? CW : 10;
  localparam logic [PW:0]   CAP_SUM  = (PW + 1)'(CAPACITY);
  localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  // captured request
  logic [3:0]            req_q;
  logic [9:0]            idx_q;
  logic [DATA_WIDTH-1:0] val_q;

  // architectural state
  logic [PW-1:0] head;
  logic [CW-1:0] cnt;
  logic          rev;

  // decoded request
  logic [PW-1:0] off_q;
  logic [1:0]    st_q;
  logic          we_q, re_q, push_q, pop_q, right_q, tog_q;
  logic          re_d;
  logic [DATA_WIDTH-1:0] rdata;

  logic [PW-1:0] off_c;
  logic [1:0]    st_c;
  logic          we_c, re_c, push_c, pop_c, right_c, tog_c;
  logic [CMPW-1:0] idx_ext, cnt_ext, cnt_m1_ext, mirror;
  logic          full, empty, in_range;

  logic [PW:0]   slot_sum;
  logic [PW-1:0] slot, head_inc;

  assign idx_ext    = CMPW'(idx_q);
  assign cnt_ext    = CMPW'(cnt);
  assign cnt_m1_ext = cnt_ext - 1'b1;
  assign mirror     = cnt_m1_ext - idx_ext;
  assign full       = (cnt == CAP_CNT);
  assign empty      = (cnt == '0);
  assign in_range   = (idx_ext < cnt_ext);

  always_comb begin
    off_c   = '0;
    st_c    = rrdq_pkg::STAT_OK;
    we_c    = 1'b0;
    re_c    = 1'b0;
    push_c  = 1'b0;
    pop_c   = 1'b0;
    right_c = 1'b0;
    tog_c   = 1'b0;
    case (req_q)
      rrdq_pkg::REQ_PUSH_LEFT, rrdq_pkg::REQ_PUSH_RIGHT: begin
        right_c = (req_q == rrdq_pkg::REQ_PUSH_RIGHT) ^ rev;
        // left push writes one slot before head
        off_c   = right_c ? cnt[PW-1:0] : LAST_POS;
        if (full) begin
          st_c = rrdq_pkg::STAT_FULL;
        end else begin
          we_c   = 1'b1;
          push_c = 1'b1;
        end
      end
      rrdq_pkg::REQ_POP_LEFT, rrdq_pkg::REQ_POP_RIGHT: begin
        right_c = (req_q == rrdq_pkg::REQ_POP_RIGHT) ^ rev;
        if (empty) begin
          st_c = rrdq_pkg::STAT_EMPTY;
        end else begin
          pop_c = 1'b1;
        end
      end
      rrdq_pkg::REQ_PEEK_LEFT, rrdq_pkg::REQ_PEEK_RIGHT: begin
        right_c = (req_q == rrdq_pkg::REQ_PEEK_RIGHT) ^ rev;
        off_c   = right_c ? cnt_m1_ext[PW-1:0] : '0;
        if (empty) begin
          st_c = rrdq_pkg::STAT_EMPTY;
        end else begin
          re_c = 1'b1;
        end
      end
      rrdq_pkg::REQ_GET, rrdq_pkg::REQ_SET: begin
        off_c = rev ? mirror[PW-1:0] : idx_ext[PW-1:0];
        if (!in_range) begin
          st_c = rrdq_pkg::STAT_RANGE;
        end else if (req_q == rrdq_pkg::REQ_GET) begin
          re_c = 1'b1;
        end else begin
          we_c = 1'b1;
        end
      end
      rrdq_pkg::REQ_REVERSE: tog_c = 1'b1;
      default: ;
    endcase
  end

  // physical slot: (head + offset) mod capacity, sum stays below twice capacity
  assign slot_sum = {1'b0, head} + {1'b0, off_q};
  always_comb begin
    slot = slot_sum[PW-1:0];
    if (slot_sum >= CAP_SUM) begin
      slot = PW'(slot_sum - CAP_SUM);
    end
  end
  assign head_inc = (head == LAST_POS) ? '0 : head + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req_type;
      idx_q <= index;
      val_q <= DATA_WIDTH'(value);
    end
    if (cmd.decode) begin
      off_q   <= off_c;
      st_q    <= st_c;
      we_q    <= we_c;
      re_q    <= re_c;
      push_q  <= push_c;
      pop_q   <= pop_c;
      right_q <= right_c;
      tog_q   <= tog_c;
    end
    if (cmd.access) begin
      re_d <= re_q;
      if (we_q) begin
        mem[slot] <= val_q;
      end
      if (re_q) begin
        rdata <= mem[slot];
      end
    end
    if (cmd.load_out) begin
      read_data   <= re_d ? 32'(rdata) : '0;
      status      <= st_q;
      count       <= 11'(cnt);
      is_reversed <= rev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      rev  <= 1'b0;
    end else if (cmd.access) begin
      if (push_q) begin
        cnt <= cnt + 1'b1;
        if (!right_q) begin
          head <= slot;
        end
      end
      if (pop_q) begin
        cnt <= cnt - 1'b1;
        if (!right_q) begin
          head <= head_inc;
        end
      end
      if (tog_q) begin
        rev <= !rev;
      end
    end
  end

endmodule

@@ hdl/reversible_ring_deque_unit.sv @@
// a word passes the decode, access and result states; the load waits while the output is held
// no new word until the last result is loaded; decode, store access and result load run in turn
// the single-port element store is touched once per word, in the access step
// the next word is accepted while the previous result still waits at the output
// reset: head, count and reversal cleared, output empty; store contents undefined until written
module reversible_ring_deque_unit #(
  parameter int CAPACITY   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [9:0]  index,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [1:0]  status,
  output logic [10:0] count,
  output logic        is_reversed
);

  rrdq_pkg::rrdq_cmd_t cmd;

  rrdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rrdq_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .index       (index),
    .value       (value),
    .read_data   (read_data),
    .status      (status),
    .count       (count),
    .is_reversed (is_reversed)
  );

endmodule

@@ tb/sv/rrdq_checker.sv @@
// rrdq_checker: follows accepted requests, predicts each deque result and compares it
module rrdq_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [9:0]  index,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic [1:0]  status,
  input  logic [10:0] count,
  input  logic        is_reversed,
  output int          errors,
  output int          waiting,
  output logic [10:0] held
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [10:0] DEPTH = 11'd1024;

  typedef struct packed {
    logic [31:0] rd;
    logic [1:0]  st;
    logic [10:0] cnt;
    logic        rev;
  } deque_result_t;

  logic [31:0]   slots [0:1023];
  logic [9:0]    head;
  logic [10:0]   level;
  logic          flip;
  deque_result_t pending_results [$];
  int            fail_cnt = 0;

  task automatic apply_request(input logic [3:0] rt, input logic [9:0] idx,
                               input logic [31:0] val, output deque_result_t res);
    logic        right;
    logic [10:0] off;
    logic [9:0]  slot;
    res = '0;
    res.st = rrdq_pkg::STAT_OK;
    // left and right swap while reversed
    right = flip ^ (rt == rrdq_pkg::REQ_PUSH_RIGHT || rt == rrdq_pkg::REQ_POP_RIGHT ||
                    rt == rrdq_pkg::REQ_PEEK_RIGHT);
    case (rt)
      rrdq_pkg::REQ_PUSH_LEFT, rrdq_pkg::REQ_PUSH_RIGHT: begin
        if (level == DEPTH) begin
          res.st = rrdq_pkg::STAT_FULL;
        end else begin
          if (right) begin
            slot = head + level[9:0];
            slots[slot] = val;
          end else begin
            head = head - 10'd1;
            slots[head] = val;
          end
          level = level + 11'd1;
        end
      end
      rrdq_pkg::REQ_POP_LEFT, rrdq_pkg::REQ_POP_RIGHT: begin
        if (level == 11'd0) begin
          res.st = rrdq_pkg::STAT_EMPTY;
        end else begin
          if (!right) head = head + 10'd1;
          level = level - 11'd1;
        end
      end
      rrdq_pkg::REQ_PEEK_LEFT, rrdq_pkg::REQ_PEEK_RIGHT: begin
        if (level == 11'd0) begin
          res.st = rrdq_pkg::STAT_EMPTY;
        end else begin
          off = right ? level - 11'd1 : 11'd0;
          slot = head + off[9:0];
          res.rd = slots[slot];
        end
      end
      rrdq_pkg::REQ_GET, rrdq_pkg::REQ_SET: begin
        if ({1'b0, idx} >= level) begin
          res.st = rrdq_pkg::STAT_RANGE;
        end else begin
          // logical index mirrors while reversed
          off = flip ? level - 11'd1 - {1'b0, idx} : {1'b0, idx};
          slot = head + off[9:0];
          if (rt == rrdq_pkg::REQ_GET) res.rd = slots[slot];
          else slots[slot] = val;
        end
      end
      rrdq_pkg::REQ_REVERSE: begin
        flip = ~flip;
      end
      default: begin
      end
    endcase
    res.cnt = level;
    res.rev = flip;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst) begin
      head = '0;
      level = '0;
      flip = 1'b0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(req_type, index, value, want);
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {read_data, status, count, is_reversed};
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected word rd %h st %0d cnt %0d rev %0d", $realtime,
                     got.rd, got.st, got.cnt, got.rev);
        end else begin
          want = pending_results.pop_front();
          if (got.rd !== want.rd || got.st !== want.st || got.cnt !== want.cnt ||
              got.rev !== want.rev) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: exp rd %h st %0d cnt %0d rev %0d got rd %h st %0d cnt %0d rev %0d",
                       $realtime, want.rd, want.st, want.cnt, want.rev,
                       got.rd, got.st, got.cnt, got.rev);
          end
        end
      end
    end
    errors  <= fail_cnt;
    waiting <= pending_results.size();
    held    <= level;
  end

endmodule

@@ tb/sv/tb_reversible_ring_deque_unit.sv @@
// tb_reversible_ring_deque_unit: request stimulus, result backpressure and final verdict
module tb_reversible_ring_deque_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  req_type;
  logic [9:0]  index;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic [1:0]  status;
  logic [10:0] count;
  logic        is_reversed;
  int          errors;
  int          waiting;
  logic [10:0] held;

  bit calm = 1'b0;
  bit hold_go = 1'b0;

  always #2 clk = ~clk;

  reversible_ring_deque_unit dut (.*);

  rrdq_checker watch (.*);

  task automatic offer_word(input logic [3:0] rt, input logic [9:0] idx,
                            input logic [31:0] val);
    in_valid <= 1'b1;
    req_type <= rt;
    index    <= idx;
    value    <= val;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic draw_request(input mix_t mix, output logic [3:0] rt,
                              output logic [9:0] idx, output logic [31:0] val);
    int r;
    int k;
    int cut_push, cut_pop, cut_peek, cut_get, cut_set, cut_rev;
    case (mix)
      MIX_FILL: begin
        cut_push = 96; cut_pop = 97; cut_peek = 98; cut_get = 99; cut_set = 100; cut_rev = 100;
      end
      MIX_DRAIN: begin
        cut_push = 10; cut_pop = 55; cut_peek = 67; cut_get = 80; cut_set = 92; cut_rev = 97;
      end
      default: begin
        cut_push = 30; cut_pop = 45; cut_peek = 57; cut_get = 73; cut_set = 89; cut_rev = 96;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < cut_push)
      rt = $urandom_range(0, 1) ? rrdq_pkg::REQ_PUSH_RIGHT : rrdq_pkg::REQ_PUSH_LEFT;
    else if (r < cut_pop)
      rt = $urandom_range(0, 1) ? rrdq_pkg::REQ_POP_RIGHT : rrdq_pkg::REQ_POP_LEFT;
    else if (r < cut_peek)
      rt = $urandom_range(0, 1) ? rrdq_pkg::REQ_PEEK_RIGHT : rrdq_pkg::REQ_PEEK_LEFT;
    else if (r < cut_get) rt = rrdq_pkg::REQ_GET;
    else if (r < cut_set) rt = rrdq_pkg::REQ_SET;
    else if (r < cut_rev) rt = rrdq_pkg::REQ_REVERSE;
    else rt = rrdq_pkg::REQ_REVERSE + 4'($urandom_range(1, 7));  // unused codes
    // mostly in range, some at the boundary, some anywhere
    k = $urandom_range(0, 7);
    if (k == 0 || held == 11'd0) idx = 10'($urandom);
    else if (k == 1 && held < 11'd1024) idx = held[9:0];
    else idx = 10'($urandom_range(0, held - 1));
    k = $urandom_range(0, 15);
    if (k == 0) val = '1;
    else if (k == 1) val = '0;
    else val = $urandom;
  endtask

  initial begin
    logic [3:0]  rt;
    logic [9:0]  idx;
    logic [31:0] val;
    int          n;
    int          extra;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    req_type <= rrdq_pkg::REQ_PUSH_LEFT;
    index    <= '0;
    value    <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty store, out of range, then a few elements in both orientations
    offer_word(rrdq_pkg::REQ_POP_LEFT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_POP_RIGHT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_PEEK_LEFT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_PEEK_RIGHT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_GET, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_SET, 10'd1023, 32'hffff_ffff);
    offer_word(rrdq_pkg::REQ_PUSH_LEFT, 10'd0, 32'hffff_ffff);
    offer_word(rrdq_pkg::REQ_PUSH_RIGHT, 10'd1023, 32'h0000_0000);
    offer_word(rrdq_pkg::REQ_PUSH_LEFT, 10'd0, 32'h5a5a_5a5a);
    offer_word(rrdq_pkg::REQ_PEEK_LEFT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_PEEK_RIGHT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_GET, 10'd2, 32'd0);
    offer_word(rrdq_pkg::REQ_GET, 10'd3, 32'd0);
    offer_word(rrdq_pkg::REQ_SET, 10'd1, 32'h1234_5678);
    offer_word(rrdq_pkg::REQ_REVERSE, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_PEEK_LEFT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_GET, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_PUSH_LEFT, 10'd0, 32'hc0ff_ee00);
    offer_word(rrdq_pkg::REQ_POP_RIGHT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_SET, 10'd0, 32'hffff_ffff);
    offer_word(rrdq_pkg::REQ_REVERSE + 4'd7, 10'd1023, 32'hffff_ffff);
    offer_word(rrdq_pkg::REQ_REVERSE + 4'd1, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_REVERSE, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_POP_LEFT, 10'd0, 32'd0);
    offer_word(rrdq_pkg::REQ_GET, 10'd1023, 32'd0);

    for (n = 0; n < 40; n++) begin
      draw_request(MIX_BALANCED, rt, idx, val);
      offer_word(rt, idx, val);
    end

    // push-heavy until the store is full, then a few pushes against it
    n = 0;
    extra = 0;
    while (n < 2000 && extra < 12) begin
      if (n == 200) hold_go = 1'b1;
      draw_request(MIX_FILL, rt, idx, val);
      offer_word(rt, idx, val);
      if (held == 11'd1024) extra++;
      n++;
    end

    for (n = 0; n < 60; n++) begin
      if (n == 30) calm = 1'b1;
      draw_request(MIX_DRAIN, rt, idx, val);
      offer_word(rt, idx, val);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: short random stalls, one long hold-off while the sender keeps going
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #800_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rrdq_pkg.sv
hdl/rrdq_ctrl.sv
hdl/rrdq_dpath.sv
hdl/reversible_ring_deque_unit.sv
tb/sv/rrdq_checker.sv
tb/sv/tb_reversible_ring_deque_unit.sv
